/* rtl/vmix_pkg.sv */
// shared types and constants of the voice mixer
`default_nettype none
package vmix_pkg;

  localparam int unsigned VOICES      = 8;
  localparam int unsigned VIDX_W      = 3;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned SOUNDS      = 32;
  localparam int unsigned SID_W       = 5;
  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned MEM_AW      = SID_W + ADDR_W;
  localparam int unsigned IN_DATA_W   = 112;
  localparam int unsigned OUT_DATA_W  = 24;
  localparam int unsigned MIX_W       = 36;

  localparam logic [15:0] GAIN_RESET  = 16'd22938;
  localparam logic [30:0] LIM_KNEE    = 31'd1020054733;
  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [31:0] RECIP_TEN   = 32'd3435973837;
  localparam logic [7:0]  PRI_TOP     = 8'd255;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_LEN   = 2'd2,
    ACT_PLAY  = 2'd3
  } action_e;

  typedef struct packed {
    logic              capture;
    logic              mem_wr;
    logic              len_wr;
    logic              scan_step;
    logic              play_commit;
    logic              tick_rd;
    logic              tick_mul;
    logic              tick_acc;
    logic              lim0;
    logic              lim1;
    logic              lim2;
    logic              lim3;
    logic              out_load;
    logic [VIDX_W-1:0] vidx;
  } vmix_cmd_t;

endpackage
`default_nettype wire

/* rtl/vmix_dp.sv */
// datapath: sample memory, sound and voice tables, mixer and limiter
`default_nettype none
module vmix_dp
  import vmix_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vmix_cmd_t             cmd_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic                  gain_we_i,
  input  wire logic [15:0]           gain_i,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  logic signed [15:0] mem_q [2**MEM_AW];
  logic signed [15:0] mem_rd_q;
  logic [MEM_AW-1:0]  mem_ra;

  logic [15:0]        master_q;
  logic [SID_W-1:0]   sid_q;
  logic [ADDR_W-1:0]  addr_q;
  logic signed [15:0] sval_q;
  logic [LEN_W-1:0]   len_in_q;
  logic [7:0]         pri_q;
  logic [3:0]         lim_q;
  logic [31:0]        cool_q;
  logic [15:0]        gain_q;

  logic [LEN_W-1:0]   slen_q [SOUNDS];
  logic [LEN_W-1:0]   len_rd_q;
  logic [SID_W-1:0]   len_ra;
  logic [31:0]        last_q [SOUNDS];
  logic [31:0]        tick_q;

  logic [VOICES-1:0]  v_act_q;
  logic [SID_W-1:0]   v_snd_q [VOICES];
  logic [LEN_W-1:0]   v_cur_q [VOICES];
  logic [16:0]        v_vol_q [VOICES];
  logic [7:0]         v_pri_q [VOICES];

  logic [CNT_W-1:0]   cnt_q;
  logic               idle_found_q;
  logic [VIDX_W-1:0]  idle_idx_q;
  logic [7:0]         low_q;
  logic               low_valid_q;
  logic [VIDX_W-1:0]  low_idx_q;
  logic [31:0]        vol_prod_q;

  logic signed [33:0] prod_q;
  logic signed [MIX_W-1:0] mix_q;
  logic               sign_q;
  logic               over_q;
  logic [MIX_W-1:0]   mag_q;
  logic [30:0]        dlt_q;
  logic [27:0]        quo_q;
  logic [30:0]        m2_q;

  logic               r_started_q;
  logic [VIDX_W-1:0]  r_slot_q;
  logic               r_stole_q;
  logic [15:0]        r_sample_q;
  logic [OUT_DATA_W-1:0] out_q;

  logic               play_ok;
  logic [VIDX_W-1:0]  play_slot;
  logic               play_stole;
  logic [31:0]        elapsed;
  logic [MIX_W-1:0]   mag_d;
  logic [MIX_W-1:0]   dlt_d;
  logic [62:0]        quo_prod;
  logic [30:0]        knee_sum;
  logic [45:0]        scale_prod;
  logic [15:0]        scaled;
  logic [LEN_W-1:0]   len_sat;

  assign mem_ra = {v_snd_q[cmd_i.vidx], v_cur_q[cmd_i.vidx][ADDR_W-1:0]};
  assign len_ra = cmd_i.tick_rd ? v_snd_q[cmd_i.vidx] : sid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[{sid_q, addr_q}] <= sval_q;
    end
    mem_rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sid_q    <= in_data_i[4:0];
      addr_q   <= in_data_i[16:5];
      sval_q   <= in_data_i[32:17];
      len_in_q <= in_data_i[45:33];
      pri_q    <= in_data_i[53:46];
      lim_q    <= in_data_i[57:54];
      cool_q   <= in_data_i[89:58];
      gain_q   <= in_data_i[105:90];
    end
    len_rd_q   <= slen_q[len_ra];
    vol_prod_q <= 32'(gain_q) * 32'(master_q);
  end

  assign len_sat = (len_in_q > LEN_W'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES) : len_in_q;

  // play decision
  assign elapsed = tick_q - last_q[sid_q];
  always_comb begin
    play_ok    = 1'b1;
    play_slot  = idle_idx_q;
    play_stole = 1'b0;
    if ((32'(sid_q) >= SOUNDS) || (len_rd_q == '0) || (elapsed < cool_q)) begin
      play_ok = 1'b0;
    end
    if ((lim_q != '0) && (cnt_q >= lim_q)) begin
      play_ok = 1'b0;
    end
    if (!idle_found_q) begin
      play_slot  = low_idx_q;
      play_stole = 1'b1;
      if (!low_valid_q || (pri_q <= low_q)) begin
        play_ok = 1'b0;
      end
    end
  end

  // limiter arithmetic
  assign mag_d      = mix_q[MIX_W-1] ? MIX_W'(-mix_q) : MIX_W'(mix_q);
  assign dlt_d      = mag_d - MIX_W'(LIM_KNEE);
  assign quo_prod   = 63'(dlt_q) * 63'(RECIP_TEN);
  assign knee_sum   = LIM_KNEE + 31'(quo_q);
  assign scale_prod = 46'(m2_q) * 46'(32767);
  assign scaled     = scale_prod[45:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q     <= GAIN_RESET;
      tick_q       <= '0;
      v_act_q      <= '0;
      cnt_q        <= '0;
      idle_found_q <= 1'b0;
      idle_idx_q   <= '0;
      low_q        <= PRI_TOP;
      low_valid_q  <= 1'b0;
      low_idx_q    <= '0;
      mix_q        <= '0;
      prod_q       <= '0;
      r_started_q  <= 1'b0;
      r_slot_q     <= '0;
      r_stole_q    <= 1'b0;
      r_sample_q   <= '0;
      out_q        <= '0;
      for (int i = 0; i < SOUNDS; i++) begin
        slen_q[i] <= '0;
        last_q[i] <= '0;
      end
      for (int i = 0; i < VOICES; i++) begin
        v_snd_q[i] <= '0;
        v_cur_q[i] <= '0;
        v_vol_q[i] <= '0;
        v_pri_q[i] <= '0;
      end
    end else begin
      if (gain_we_i) begin
        master_q <= gain_i;
      end
      if (cmd_i.capture) begin
        cnt_q        <= '0;
        idle_found_q <= 1'b0;
        idle_idx_q   <= '0;
        low_q        <= PRI_TOP;
        low_valid_q  <= 1'b0;
        low_idx_q    <= '0;
        mix_q        <= '0;
        r_started_q  <= 1'b0;
        r_slot_q     <= '0;
        r_stole_q    <= 1'b0;
        r_sample_q   <= '0;
      end
      if (cmd_i.len_wr && (32'(sid_q) < SOUNDS)) begin
        slen_q[sid_q] <= len_sat;
      end
      if (cmd_i.scan_step) begin
        if (v_act_q[cmd_i.vidx] && (v_snd_q[cmd_i.vidx] == sid_q)) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (!v_act_q[cmd_i.vidx] && !idle_found_q) begin
          idle_found_q <= 1'b1;
          idle_idx_q   <= cmd_i.vidx;
        end
        if (v_pri_q[cmd_i.vidx] < low_q) begin
          low_q       <= v_pri_q[cmd_i.vidx];
          low_valid_q <= 1'b1;
          low_idx_q   <= cmd_i.vidx;
        end
      end
      if (cmd_i.play_commit && play_ok) begin
        v_act_q[play_slot] <= 1'b1;
        v_snd_q[play_slot] <= sid_q;
        v_cur_q[play_slot] <= '0;
        v_vol_q[play_slot] <= vol_prod_q[31:15];
        v_pri_q[play_slot] <= pri_q;
        last_q[sid_q]      <= tick_q;
        r_started_q        <= 1'b1;
        r_slot_q           <= play_slot;
        r_stole_q          <= play_stole;
      end
      if (cmd_i.tick_mul) begin
        prod_q <= '0;
        if (v_act_q[cmd_i.vidx]) begin
          if (v_cur_q[cmd_i.vidx] < len_rd_q) begin
            prod_q <= $signed(mem_rd_q) * $signed({1'b0, v_vol_q[cmd_i.vidx]});
            v_cur_q[cmd_i.vidx] <= v_cur_q[cmd_i.vidx] + 1'b1;
          end else begin
            v_act_q[cmd_i.vidx] <= 1'b0;
          end
        end
      end
      if (cmd_i.tick_acc) begin
        mix_q <= mix_q + {{(MIX_W-34){prod_q[33]}}, prod_q};
      end
      if (cmd_i.lim3) begin
        r_sample_q <= sign_q ? 16'(-scaled) : scaled;
        tick_q     <= tick_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_q <= {3'b000, r_stole_q, r_slot_q, r_started_q, r_sample_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lim0) begin
      sign_q <= mix_q[MIX_W-1];
      mag_q  <= mag_d;
      over_q <= mag_d > MIX_W'(LIM_KNEE);
      dlt_q  <= (dlt_d > MIX_W'(Q30_ONE)) ? Q30_ONE : dlt_d[30:0];
    end
    if (cmd_i.lim1) begin
      quo_q <= quo_prod[62:35];
    end
    if (cmd_i.lim2) begin
      if (over_q) begin
        m2_q <= (knee_sum > Q30_ONE) ? Q30_ONE : knee_sum;
      end else begin
        m2_q <= (mag_q > MIX_W'(Q30_ONE)) ? Q30_ONE : mag_q[30:0];
      end
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

/* rtl/vmix_ctrl.sv */
// controller: sequences each item through the datapath
`default_nettype none
module vmix_ctrl
  import vmix_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_action_i,
  input  wire logic       out_ready_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output vmix_cmd_t       cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_WR    = 13'b0000000000010,
    S_LEN   = 13'b0000000000100,
    S_PSCAN = 13'b0000000001000,
    S_PDEC  = 13'b0000000010000,
    S_TRD   = 13'b0000000100000,
    S_TMUL  = 13'b0000001000000,
    S_TACC  = 13'b0000010000000,
    S_L0    = 13'b0000100000000,
    S_L1    = 13'b0001000000000,
    S_L2    = 13'b0010000000000,
    S_L3    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [VIDX_W-1:0] vidx_q, vidx_d;
  logic              ovalid_q, ovalid_d;
  logic              last_voice;

  assign last_voice = (vidx_q == VIDX_W'(VOICES - 1));
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    vidx_d  = vidx_q;
    cmd_o   = '0;
    cmd_o.vidx = vidx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          vidx_d = '0;
          unique case (action_e'(in_action_i))
            ACT_TICK:  state_d = S_TRD;
            ACT_WRITE: state_d = S_WR;
            ACT_LEN:   state_d = S_LEN;
            ACT_PLAY:  state_d = S_PSCAN;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_WR: begin
        cmd_o.mem_wr = 1'b1;
        state_d = S_DONE;
      end
      S_LEN: begin
        cmd_o.len_wr = 1'b1;
        state_d = S_DONE;
      end
      S_PSCAN: begin
        cmd_o.scan_step = 1'b1;
        if (last_voice) begin
          state_d = S_PDEC;
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end
      S_PDEC: begin
        cmd_o.play_commit = 1'b1;
        state_d = S_DONE;
      end
      S_TRD: begin
        cmd_o.tick_rd = 1'b1;
        state_d = S_TMUL;
      end
      S_TMUL: begin
        cmd_o.tick_mul = 1'b1;
        state_d = S_TACC;
      end
      S_TACC: begin
        cmd_o.tick_acc = 1'b1;
        if (last_voice) begin
          state_d = S_L0;
        end else begin
          vidx_d  = vidx_q + 1'b1;
          state_d = S_TRD;
        end
      end
      S_L0: begin
        cmd_o.lim0 = 1'b1;
        state_d = S_L1;
      end
      S_L1: begin
        cmd_o.lim1 = 1'b1;
        state_d = S_L2;
      end
      S_L2: begin
        cmd_o.lim2 = 1'b1;
        state_d = S_L3;
      end
      S_L3: begin
        cmd_o.lim3 = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      vidx_q   <= vidx_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/voice_mixer_with_priority_steal_unit.sv */
// top level of the polyphonic voice mixer with priority stealing
//
//  channel      direction  handshake               payload
//  s_axis       in         tvalid / tready         tuser action, tdata item fields
//  m_axis       out        tvalid / tready         tdata result fields
//  master_gain  in         we, write when high     16-bit Q1.15 gain
//
//  tick: read, multiply and accumulate for each voice, then the limiter and hand-off
//  play: a scan of the voice table, one voice at a time, then decision and hand-off
//  write or length: one write, hand-off; voices share one multiplier and memory port
//  reset clears all tables but the sample memory; no clearing pass
//  a finished item waits in the output register while the next is taken
`default_nettype none
module voice_mixer_with_priority_steal_unit
  import vmix_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // sound, sample_addr, sample_value, length, request_priority,
  // concurrent_limit, cooldown_ticks, gain
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // sample_out, started, voice_slot, stole
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  master_gain_we_i,
  input  wire logic [15:0]           master_gain_i
);

  vmix_cmd_t cmd;

  vmix_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  vmix_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .gain_we_i  (master_gain_we_i),
    .gain_i     (master_gain_i),
    .out_data_o (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item taken while busy");

  a_stole_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[20]) |-> m_axis_tdata[16])
    else $error("steal without start");

  a_slot_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[16]) |-> (m_axis_tdata[19:17] == 3'd0))
    else $error("slot without start");

  a_start_no_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("sample on a play result");
`endif

endmodule
`default_nettype wire

/* tb/tb_voice_mixer_with_priority_steal_unit.sv */
// self-checking testbench of the voice mixer with priority stealing
`timescale 1ns / 100ps
module tb_voice_mixer_with_priority_steal_unit;
  import vmix_pkg::*;

  typedef struct {
    action_e     act;
    logic [4:0]  sid;
    logic [11:0] addr;
    logic [15:0] val;
    logic [12:0] len;
    logic [7:0]  pri;
    logic [3:0]  lim;
    logic [31:0] cool;
    logic [15:0] gain;
  } item_t;

  typedef struct packed {
    logic        stole;
    logic [2:0]  slot;
    logic        started;
    logic [15:0] sample;
  } mix_res_t;

  typedef struct {
    item_t    it;
    logic     known;
    mix_res_t res;
  } row_t;

  localparam longint KNEE = 64'sd1020054733;
  localparam longint ONE  = 64'sd1073741824;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = ACT_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  master_gain_we_i = 1'b0;
  logic [15:0]           master_gain_i = '0;

  voice_mixer_with_priority_steal_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .master_gain_we_i (master_gain_we_i),
    .master_gain_i    (master_gain_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mixer state as predicted
  shortint     pcm_mem [SOUNDS*MAX_SAMPLES];
  logic [12:0] snd_len [SOUNDS];
  logic [31:0] last_start [SOUNDS];
  logic [31:0] tick_cnt;
  logic        v_on [VOICES];
  logic [4:0]  v_snd [VOICES];
  logic [12:0] v_pos [VOICES];
  logic [16:0] v_vol [VOICES];
  logic [7:0]  v_pri [VOICES];
  logic [15:0] gain_reg;

  int          wr_next [SOUNDS];
  mix_res_t    pending_q [$];
  int          errors = 0;
  int          n_ticks = 0, n_starts = 0, n_steals = 0, n_items = 0;
  logic        no_idle = 1'b0;

  function automatic mix_res_t predict_mixer(item_t it);
    mix_res_t r;
    longint   acc;
    int       slot;
    int       cnt;
    int       low;
    r = '0;
    acc = 0;
    slot = -1;
    cnt = 0;
    low = 255;
    case (it.act)
      ACT_TICK: begin
        for (int v = 0; v < VOICES; v++) begin
          if (v_on[v]) begin
            if (v_pos[v] >= snd_len[v_snd[v]]) begin
              v_on[v] = 1'b0;
            end else begin
              acc += longint'(pcm_mem[{v_snd[v], v_pos[v][11:0]}]) * longint'(v_vol[v]);
              v_pos[v] = v_pos[v] + 13'd1;
            end
          end
        end
        if (acc > KNEE) acc = KNEE + (acc - KNEE) / 10;
        if (acc < -KNEE) acc = -KNEE + (acc + KNEE) / 10;
        if (acc > ONE) acc = ONE;
        if (acc < -ONE) acc = -ONE;
        acc = (acc >= 0) ? (acc * 32767) / ONE : -(((-acc) * 32767) / ONE);
        r.sample = acc[15:0];
        tick_cnt = tick_cnt + 32'd1;
      end
      ACT_WRITE: pcm_mem[{it.sid, it.addr}] = shortint'(it.val);
      ACT_LEN: snd_len[it.sid] = (it.len > MAX_SAMPLES) ? 13'(MAX_SAMPLES) : it.len;
      default: begin
        if (snd_len[it.sid] == 0) return r;
        if (tick_cnt - last_start[it.sid] < it.cool) return r;
        for (int v = 0; v < VOICES; v++)
          if (v_on[v] && v_snd[v] == it.sid) cnt++;
        if (it.lim != 0 && cnt >= it.lim) return r;
        for (int v = VOICES - 1; v >= 0; v--)
          if (!v_on[v]) slot = v;
        if (slot < 0) begin
          for (int v = 0; v < VOICES; v++) begin
            if (v_pri[v] < low) begin
              low = int'(v_pri[v]);
              slot = v;
            end
          end
          if (slot < 0 || it.pri <= low) return r;
          r.stole = 1'b1;
        end
        v_on[slot] = 1'b1;
        v_snd[slot] = it.sid;
        v_pos[slot] = '0;
        v_vol[slot] = 17'((34'(it.gain) * 34'(gain_reg)) >> 15);
        v_pri[slot] = it.pri;
        last_start[it.sid] = tick_cnt;
        r.started = 1'b1;
        r.slot = slot[2:0];
      end
    endcase
    return r;
  endfunction

  task automatic send_item(item_t it, logic known, mix_res_t res);
    int       gap;
    mix_res_t p;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.act;
    s_axis_tdata  <= {6'b0, it.gain, it.cool, it.lim, it.pri, it.len, it.val, it.addr, it.sid};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.act == ACT_WRITE && it.addr == wr_next[it.sid]) wr_next[it.sid]++;
    p = predict_mixer(it);
    pending_q.push_back(known ? res : p);
    n_items++;
  endtask

  task automatic drain_and_set_gain(logic [15:0] g);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    master_gain_we_i <= 1'b1;
    master_gain_i    <= g;
    @(posedge clk_i);
    master_gain_we_i <= 1'b0;
    gain_reg = g;
  endtask

  function automatic item_t rand_item();
    item_t it;
    int    k;
    it.act  = action_e'($urandom_range(0, 3));
    it.sid  = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    it.addr = 12'($urandom);
    it.val  = 16'($urandom);
    it.len  = 13'($urandom);
    it.pri  = 8'($urandom);
    it.lim  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    it.cool = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
    it.gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 65535));
    k = $urandom_range(0, 99);
    if (k < 35) it.act = ACT_TICK;
    else if (k < 55) begin
      it.act = ACT_WRITE;
      if ($urandom_range(0, 1) && wr_next[it.sid] < MAX_SAMPLES) it.addr = 12'(wr_next[it.sid]);
    end else if (k < 65) begin
      it.act = ACT_LEN;
      if (wr_next[it.sid] == MAX_SAMPLES && $urandom_range(0, 3) == 0)
        it.len = 13'($urandom_range(MAX_SAMPLES, 8191));
      else if ($urandom_range(0, 4) == 0)
        it.len = 13'($urandom_range(0, wr_next[it.sid]));
      else
        it.len = 13'($urandom_range(0, (wr_next[it.sid] < 20) ? wr_next[it.sid] : 20));
    end else it.act = ACT_PLAY;
    return it;
  endfunction

  initial begin
    row_t  rows [$];
    item_t it;
    row_t  rw;
    logic [15:0] gains [4];
    for (int i = 0; i < SOUNDS*MAX_SAMPLES; i++) pcm_mem[i] = 0;
    for (int s = 0; s < SOUNDS; s++) begin
      snd_len[s] = '0;
      last_start[s] = '0;
      wr_next[s] = 0;
    end
    for (int v = 0; v < VOICES; v++) begin
      v_on[v] = 1'b0;
      v_snd[v] = '0;
      v_pos[v] = '0;
      v_vol[v] = '0;
      v_pri[v] = '0;
    end
    tick_cnt = '0;
    gain_reg = GAIN_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // preload: first 16 samples of sounds 0 to 7
    no_idle = 1'b1;
    for (int s = 0; s < 8; s++) begin
      for (int a = 0; a < 16; a++) begin
        it = rand_item();
        it.act = ACT_WRITE;
        it.sid = 5'(s);
        it.addr = 12'(a);
        send_item(it, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    // directed rows
    it = rand_item();
    it.cool = '0; it.lim = '0; it.pri = 8'd255; it.gain = 16'd32768;
    rw.known = 1'b1; rw.res = '0;
    rw.it = it; rw.it.act = ACT_TICK; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd5; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_LEN; rw.it.sid = 5'd0; rw.it.len = 13'd8191; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd0; rw.it.cool = 32'd2; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd0; rw.it.lim = 4'd1;
    rw.res = '{stole: 1'b0, slot: 3'd0, started: 1'b1, sample: 16'd0}; rows.push_back(rw);
    rw.res = '0; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_LEN; rw.it.sid = 5'd1; rw.it.len = 13'd16; rows.push_back(rw);
    rw.known = 1'b0;
    for (int i = 0; i < 7; i++) begin
      rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd1; rw.it.gain = 16'hffff;
      rows.push_back(rw);
    end
    rw.known = 1'b1;
    rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd1; rows.push_back(rw);
    rw.known = 1'b0;
    rw.it = it; rw.it.act = ACT_TICK; rows.push_back(rw);
    rw.known = 1'b1;
    rw.it = it; rw.it.act = ACT_LEN; rw.it.sid = 5'd0; rw.it.len = '0; rows.push_back(rw);
    rw.known = 1'b0;
    rw.it = it; rw.it.act = ACT_TICK; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_LEN; rw.it.sid = 5'd2; rw.it.len = 13'd16; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd2; rw.it.pri = 8'd10; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_LEN; rw.it.sid = 5'd3; rw.it.len = 13'd16; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd3; rw.it.pri = 8'd5; rw.it.gain = '0;
    rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_PLAY; rw.it.sid = 5'd3; rw.it.pri = 8'd200; rows.push_back(rw);
    rw.it = it; rw.it.act = ACT_TICK; rows.push_back(rw);
    rw.known = 1'b1;
    rw.it = it; rw.it.act = ACT_WRITE; rw.it.sid = 5'd31; rw.it.addr = 12'hfff;
    rw.it.val = 16'h8000; rows.push_back(rw);
    foreach (rows[i]) send_item(rows[i].it, rows[i].known, rows[i].res);

    // random phases over several master gains
    gains = '{16'd0, 16'd32768, 16'hffff, 16'($urandom)};
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_set_gain(gains[ph]);
      for (int n = 0; n < 140; n++) begin
        no_idle = (ph == 1 && n < 60);
        send_item(rand_item(), 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d items: %0d non-zero mixed samples, %0d voice starts, %0d steals",
             n_items, n_ticks, n_starts, n_steals);
    $display("master gains 22938, 0, 32768, 65535 and one random value");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: random back-pressure and comparison
  initial begin
    mix_res_t exp_r;
    mix_res_t got;
    int       stall;
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[20:0];
        if (pending_q.size() == 0) begin
          $error("result with nothing expected: %h", got);
          errors++;
        end else begin
          exp_r = pending_q.pop_front();
          if (got.sample !== exp_r.sample) begin
            $error("sample_out expected %0d got %0d", $signed(exp_r.sample), $signed(got.sample));
            errors++;
          end
          if (got.started !== exp_r.started) begin
            $error("started expected %0d got %0d", exp_r.started, got.started);
            errors++;
          end
          if (got.slot !== exp_r.slot) begin
            $error("voice_slot expected %0d got %0d", exp_r.slot, got.slot);
            errors++;
          end
          if (got.stole !== exp_r.stole) begin
            $error("stole expected %0d got %0d", exp_r.stole, got.stole);
            errors++;
          end
          if (exp_r.started) n_starts++;
          if (exp_r.stole) n_steals++;
          if (exp_r.sample != 0) n_ticks++;
        end
        stall = no_idle ? 0 : $urandom_range(0, 19);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* voice_mixer_with_priority_steal_unit.f */
rtl/vmix_pkg.sv
rtl/vmix_dp.sv
rtl/vmix_ctrl.sv
rtl/voice_mixer_with_priority_steal_unit.sv
tb/tb_voice_mixer_with_priority_steal_unit.sv
